@@ rtl/core/mrl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrl_pkg;

    localparam int MRL_TABLE_ENTRIES = 16;
    localparam int MRL_KEY_W = 48;
    localparam int MRL_MASK_W = 6;
    localparam int MRL_PORT_W = 8;
    localparam int MRL_STATUS_W = 2;
    localparam int MRL_MAC_BYTES = 6;

    localparam logic [MRL_MASK_W-1:0] SUFFIX_MASK = 6'd8;
    localparam logic [3:0] PREFIX_BASE = 4'd2;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [MRL_STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [MRL_STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [MRL_STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } mrl_state_t;

    typedef struct packed {
        logic                  opcode;
        logic [MRL_KEY_W-1:0]  mac_key;
        logic [MRL_MASK_W-1:0] mask_length;
        logic [MRL_PORT_W-1:0] out_port;
    } mrl_cmd_t;

    typedef struct packed {
        logic [MRL_PORT_W-1:0]   port;
        logic [MRL_STATUS_W-1:0] status;
    } mrl_res_t;

    // Word that moves down the chain, one cell per cycle.
    typedef struct packed {
        logic                  vld;
        mrl_cmd_t              cmd;
        logic                  hit;
        logic [MRL_KEY_W-1:0]  best_key;
        logic [MRL_PORT_W-1:0] best_port;
        logic                  key_found;
        logic                  free_found;
    } mrl_token_t;

    typedef struct packed {
        logic                  en;
        logic [MRL_KEY_W-1:0]  key;
        logic [MRL_MASK_W-1:0] mask;
        logic [MRL_PORT_W-1:0] port;
    } mrl_write_t;

endpackage

`default_nettype wire

@@ rtl/core/mrl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrl_cell
    import mrl_pkg::*;
#(
    parameter int TABLE_ENTRIES = MRL_TABLE_ENTRIES,
    parameter int CELL_INDEX = 0,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mrl_token_t       token_in,
    input  wire logic [IDX_W-1:0] slot_in,
    input  wire mrl_write_t       wr,
    input  wire logic [IDX_W-1:0] wr_slot,
    output mrl_token_t            token_out,
    output logic [IDX_W-1:0]      slot_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [MRL_KEY_W-1:0]  key_reg;
    logic [MRL_MASK_W-1:0] mask_reg;
    logic [MRL_PORT_W-1:0] port_reg;
    logic                  valid_reg;

    mrl_token_t       token_reg;
    mrl_token_t       token_next;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;

    logic                  wr_hit;
    logic [MRL_KEY_W-1:0]  cur_key;
    logic [MRL_MASK_W-1:0] cur_mask;
    logic [MRL_PORT_W-1:0] cur_port;
    logic                  cur_valid;

    logic [MRL_MAC_BYTES-1:0] byte_eq;
    logic [3:0]               req_bytes;
    logic                     prefix_ok;
    logic                     route_hit;
    logic                     key_eq;

    // A word entering while the previous insert writes this slot sees the new entry.
    assign wr_hit = wr.en && (wr_slot == MY_IDX);

    always_comb
    begin
        cur_key = wr_hit ? wr.key : key_reg;
        cur_mask = wr_hit ? wr.mask : mask_reg;
        cur_port = wr_hit ? wr.port : port_reg;
        cur_valid = valid_reg || wr_hit;
    end

    always_comb
    begin
        for (int b = 0; b < MRL_MAC_BYTES; b++)
        begin
            byte_eq[b] = token_in.cmd.mac_key[MRL_KEY_W-1-8*b -: 8] ==
                         cur_key[MRL_KEY_W-1-8*b -: 8];
        end
        req_bytes = {1'b0, cur_mask[5:3]} + PREFIX_BASE;
        prefix_ok = req_bytes <= 4'(MRL_MAC_BYTES);
        for (int b = 0; b < MRL_MAC_BYTES; b++)
        begin
            if ((4'(b) < req_bytes) && !byte_eq[b])
            begin
                prefix_ok = 1'b0;
            end
        end
        if (cur_mask == SUFFIX_MASK)
        begin
            route_hit = byte_eq[MRL_MAC_BYTES-1];
        end
        else
        begin
            route_hit = prefix_ok;
        end
        key_eq = cur_valid && (cur_key == token_in.cmd.mac_key);
    end

    always_comb
    begin
        token_next = token_in;
        slot_next = slot_in;
        if (token_in.cmd.opcode == OP_INSERT)
        begin
            if (!token_in.key_found && key_eq)
            begin
                token_next.key_found = 1'b1;
                slot_next = MY_IDX;
            end
            else if (!token_in.key_found && !token_in.free_found && !cur_valid)
            begin
                token_next.free_found = 1'b1;
                slot_next = MY_IDX;
            end
        end
        else
        begin
            if (cur_valid && (cur_mask != '0) && route_hit &&
                (!token_in.hit || (cur_key > token_in.best_key)))
            begin
                token_next.hit = 1'b1;
                token_next.best_key = cur_key;
                token_next.best_port = cur_port;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
            slot_reg <= '0;
        end
        else
        begin
            token_reg <= token_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_hit)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            key_reg <= wr.key;
            mask_reg <= wr.mask;
            port_reg <= wr.port;
        end
    end

    assign token_out = token_reg;
    assign slot_out = slot_reg;

endmodule

`default_nettype wire

@@ rtl/core/two_level_mac_route_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A result strobes on done when the word taken on start leaves the last cell of the chain.
// No new word is taken before that strobe; the next word may be taken in the done cycle itself.
// An insert writes its slot at the edge that ends the done cycle.
// Reset empties the table and clears the chain; the receiver cannot stall.
module two_level_mac_route_lookup
    import mrl_pkg::*;
#(
    parameter int TABLE_ENTRIES = MRL_TABLE_ENTRIES,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire mrl_cmd_t cmd,
    output logic          busy,
    output logic          done,
    output mrl_res_t      res
);

    mrl_state_t state_reg;
    mrl_state_t state_next;

    mrl_token_t       inject;
    mrl_token_t       chain_tok [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] chain_slot [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] chain_vld;
    mrl_token_t       last;
    mrl_write_t       wr;
    logic             accept;

    assign accept = start && !busy;

    always_comb
    begin
        inject = '0;
        inject.vld = accept;
        inject.cmd = cmd;
    end

    assign chain_tok[0] = inject;
    assign chain_slot[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        mrl_cell #(
            .TABLE_ENTRIES(TABLE_ENTRIES),
            .CELL_INDEX(i)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .token_in(chain_tok[i]),
            .slot_in(chain_slot[i]),
            .wr(wr),
            .wr_slot(chain_slot[TABLE_ENTRIES]),
            .token_out(chain_tok[i+1]),
            .slot_out(chain_slot[i+1])
        );
        assign chain_vld[i] = chain_tok[i+1].vld;
    end

    assign last = chain_tok[TABLE_ENTRIES];
    assign done = last.vld;

    always_comb
    begin
        wr.en = done && (last.cmd.opcode == OP_INSERT) && (last.key_found || last.free_found);
        wr.key = last.cmd.mac_key;
        wr.mask = last.cmd.mask_length;
        wr.port = last.cmd.out_port;
    end

    always_comb
    begin
        res.port = '0;
        if (last.cmd.opcode == OP_INSERT)
        begin
            res.status = (last.key_found || last.free_found) ? STATUS_OK : STATUS_FULL;
        end
        else if (last.hit)
        begin
            res.port = last.best_port;
            res.status = STATUS_OK;
        end
        else
        begin
            res.status = STATUS_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                busy = !done;
                if (done && !start)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_vld))
        else $error("more than one word in the cell chain");

    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_SCAN)
        else $error("result strobe outside a scan");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("not busy after a word was taken");

    a_write_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (done && res.status == STATUS_OK))
        else $error("table write without a finished insert");
`endif

endmodule

`default_nettype wire

@@ test/two_level_mac_route_lookup_tb.sv @@
`timescale 1ns / 1ps

module two_level_mac_route_lookup_tb;
    import mrl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 400;

    logic     clk;
    logic     rst_n;
    logic     start;
    mrl_cmd_t cmd;
    logic     busy;
    logic     done;
    mrl_res_t res;

    logic [MRL_KEY_W-1:0]  tbl_key   [MRL_TABLE_ENTRIES];
    logic [MRL_MASK_W-1:0] tbl_mask  [MRL_TABLE_ENTRIES];
    logic [MRL_PORT_W-1:0] tbl_port  [MRL_TABLE_ENTRIES];
    logic                  tbl_valid [MRL_TABLE_ENTRIES];
    logic [MRL_KEY_W-1:0]  key_bases [4];

    mrl_res_t route_answers[$];
    int       mismatch_count;
    int       cycle_count;
    logic     idle_on;

    two_level_mac_route_lookup dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .res   (res)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int equal_leading_bytes(logic [MRL_KEY_W-1:0] a,
                                               logic [MRL_KEY_W-1:0] b);
        int n;
        n = 0;
        while (n < MRL_MAC_BYTES && a[MRL_KEY_W-1-8*n -: 8] == b[MRL_KEY_W-1-8*n -: 8])
        begin
            n++;
        end
        return n;
    endfunction

    function automatic logic route_hit(logic [MRL_KEY_W-1:0] dest,
                                       logic [MRL_KEY_W-1:0] key,
                                       logic [MRL_MASK_W-1:0] mask);
        if (mask == SUFFIX_MASK)
        begin
            return dest[7:0] == key[7:0];
        end
        return equal_leading_bytes(dest, key) >= int'(mask / 8) + int'(PREFIX_BASE);
    endfunction

    // Applies one word to the table copy and returns the answer the block owes.
    function automatic mrl_res_t route_predict(mrl_cmd_t c);
        mrl_res_t             r;
        int                   slot;
        logic                 hit;
        logic [MRL_KEY_W-1:0] best_key;
        r.port = '0;
        r.status = STATUS_OK;
        slot = -1;
        if (c.opcode == OP_INSERT)
        begin
            for (int i = 0; i < MRL_TABLE_ENTRIES && slot < 0; i++)
            begin
                if (tbl_valid[i] && tbl_key[i] == c.mac_key)
                begin
                    slot = i;
                end
            end
            for (int i = 0; i < MRL_TABLE_ENTRIES && slot < 0; i++)
            begin
                if (!tbl_valid[i])
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                tbl_key[slot] = c.mac_key;
                tbl_mask[slot] = c.mask_length;
                tbl_port[slot] = c.out_port;
                tbl_valid[slot] = 1'b1;
            end
        end
        else
        begin
            hit = 1'b0;
            best_key = '0;
            for (int i = 0; i < MRL_TABLE_ENTRIES; i++)
            begin
                if (tbl_valid[i] && tbl_mask[i] != '0 &&
                    route_hit(c.mac_key, tbl_key[i], tbl_mask[i]) &&
                    (!hit || tbl_key[i] > best_key))
                begin
                    hit = 1'b1;
                    best_key = tbl_key[i];
                    r.port = tbl_port[i];
                end
            end
            if (!hit)
            begin
                r.status = STATUS_MISS;
            end
        end
        return r;
    endfunction

    function automatic logic key_present(logic [MRL_KEY_W-1:0] key);
        for (int i = 0; i < MRL_TABLE_ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_key[i] == key)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic table_full();
        for (int i = 0; i < MRL_TABLE_ENTRIES; i++)
        begin
            if (!tbl_valid[i])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [MRL_KEY_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [MRL_KEY_W-1:0] fresh_key();
        logic [MRL_KEY_W-1:0] key;
        int                   keep;
        if ($urandom_range(0, 7) == 0)
        begin
            return rand_mac();
        end
        key = key_bases[$urandom_range(0, 3)];
        keep = $urandom_range(2, 5);
        for (int i = keep; i < MRL_MAC_BYTES; i++)
        begin
            key[MRL_KEY_W-1-8*i -: 8] = 8'($urandom);
        end
        return key;
    endfunction

    function automatic logic [MRL_MASK_W-1:0] random_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return SUFFIX_MASK;
            2: return 6'($urandom_range(1, 7));
            3: return 6'($urandom_range(9, 31));
            4: return 6'($urandom_range(32, 39));
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic int random_valid_slot();
        int slots[$];
        for (int i = 0; i < MRL_TABLE_ENTRIES; i++)
        begin
            if (tbl_valid[i])
            begin
                slots.push_back(i);
            end
        end
        if (slots.size() == 0)
        begin
            return -1;
        end
        return slots[$urandom_range(0, slots.size() - 1)];
    endfunction

    function automatic mrl_cmd_t random_insert();
        mrl_cmd_t c;
        int       slot;
        c.opcode = OP_INSERT;
        c.out_port = 8'($urandom);
        c.mask_length = random_mask();
        slot = random_valid_slot();
        if (slot >= 0 && $urandom_range(0, 99) < 30)
        begin
            c.mac_key = tbl_key[slot];
        end
        else
        begin
            c.mac_key = fresh_key();
        end
        return c;
    endfunction

    // Most lookups are stored keys with a chosen number of leading bytes kept.
    function automatic mrl_cmd_t random_lookup();
        mrl_cmd_t c;
        int       slot;
        int       keep;
        int       pick;
        c.opcode = OP_LOOKUP;
        c.mask_length = 6'($urandom);
        c.out_port = 8'($urandom);
        c.mac_key = rand_mac();
        slot = random_valid_slot();
        pick = $urandom_range(0, 99);
        if (slot >= 0 && pick >= 20 && pick < 35)
        begin
            c.mac_key[7:0] = tbl_key[slot][7:0];
        end
        else if (slot >= 0 && pick >= 35)
        begin
            keep = $urandom_range(0, MRL_MAC_BYTES);
            c.mac_key = tbl_key[slot];
            for (int i = keep; i < MRL_MAC_BYTES; i++)
            begin
                if (i == keep)
                begin
                    c.mac_key[MRL_KEY_W-1-8*i -: 8] ^= 8'($urandom_range(1, 255));
                end
                else
                begin
                    c.mac_key[MRL_KEY_W-1-8*i -: 8] = 8'($urandom);
                end
            end
        end
        return c;
    endfunction

    task automatic idle_gap();
        int n;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            n = 0;
        end
        else if (pick < 85)
        begin
            n = $urandom_range(1, 4);
        end
        else if (pick < 97)
        begin
            n = $urandom_range(5, 20);
        end
        else
        begin
            n = $urandom_range(21, 60);
        end
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_word(input mrl_cmd_t c);
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        route_answers.push_back(route_predict(c));
        if (idle_on)
        begin
            idle_gap();
        end
    endtask

    task automatic send_fields(input logic op, input logic [MRL_KEY_W-1:0] key,
                               input logic [MRL_MASK_W-1:0] mask,
                               input logic [MRL_PORT_W-1:0] port_num);
        mrl_cmd_t c;
        c.opcode = op;
        c.mac_key = key;
        c.mask_length = mask;
        c.out_port = port_num;
        send_word(c);
    endtask

    always @(posedge clk)
    begin
        mrl_res_t want;
        if (rst_n && done)
        begin
            if (route_answers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual port %0h status %0d",
                         $time, res.port, res.status);
                mismatch_count++;
            end
            else
            begin
                want = route_answers.pop_front();
                if (res.port !== want.port)
                begin
                    $display("%0t: port mismatch, expected %0h, actual %0h",
                             $time, want.port, res.port);
                    mismatch_count++;
                end
                if (res.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, res.status);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_fields(OP_LOOKUP, 48'h0000_0000_0000, 6'd0, 8'h00);
        send_fields(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 6'd63, 8'hFF);
    endtask

    task automatic test_mask_modes();
        send_fields(OP_INSERT, 48'h0000_0000_0000, 6'd0, 8'hFF);
        send_fields(OP_LOOKUP, 48'h0000_0000_0000, 6'd0, 8'h00);
        send_fields(OP_INSERT, 48'hFFFF_FFFF_FFFF, 6'd63, 8'h01);
        send_fields(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 6'd0, 8'h00);
        send_fields(OP_INSERT, 48'h1234_5678_9ABC, 6'd32, 8'h20);
        send_fields(OP_LOOKUP, 48'h1234_5678_9ABC, 6'd0, 8'h00);
        send_fields(OP_LOOKUP, 48'h1234_5678_9ABD, 6'd0, 8'h00);
        send_fields(OP_INSERT, 48'hAABB_CCDD_EEBC, SUFFIX_MASK, 8'h80);
        send_fields(OP_LOOKUP, 48'h0102_0304_05BC, 6'd0, 8'h00);
        send_fields(OP_INSERT, 48'h1234_5600_0000, 6'd16, 8'h10);
        send_fields(OP_LOOKUP, 48'h1234_5600_7777, 6'd0, 8'h00);
    endtask

    task automatic test_largest_key();
        send_fields(OP_LOOKUP, 48'h1234_5678_9ABC, 6'd0, 8'h00);
        send_fields(OP_INSERT, 48'h1234_0000_0001, 6'd7, 8'h07);
        send_fields(OP_LOOKUP, 48'h1234_5600_7777, 6'd0, 8'h00);
    endtask

    task automatic test_overwrite();
        send_fields(OP_INSERT, 48'h1234_5600_0000, 6'd0, 8'h11);
        send_fields(OP_LOOKUP, 48'h1234_5600_7777, 6'd0, 8'h00);
        send_fields(OP_INSERT, 48'h0000_0000_0000, 6'd1, 8'hAB);
        send_fields(OP_LOOKUP, 48'h0000_FF00_0000, 6'd0, 8'h00);
    endtask

    task automatic run_random_traffic(input int count);
        mrl_cmd_t c;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < 35)
            begin
                c = random_insert();
            end
            else
            begin
                c = random_lookup();
            end
            send_word(c);
        end
    endtask

    task automatic test_table_full();
        logic [MRL_KEY_W-1:0] key;
        int                   slot;
        idle_on = 1'b1;
        for (int n = 0; n < MRL_TABLE_ENTRIES + 2; n++)
        begin
            do
            begin
                key = fresh_key();
            end
            while (key_present(key));
            send_fields(OP_INSERT, key, random_mask(), 8'($urandom));
        end
        slot = random_valid_slot();
        key = tbl_key[slot];
        send_fields(OP_INSERT, key, 6'd4, 8'h5A);
        send_fields(OP_LOOKUP, key, 6'd0, 8'h00);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        mismatch_count = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        for (int i = 0; i < MRL_TABLE_ENTRIES; i++)
        begin
            tbl_key[i] = '0;
            tbl_mask[i] = '0;
            tbl_port[i] = '0;
            tbl_valid[i] = 1'b0;
        end
        for (int i = 0; i < 4; i++)
        begin
            key_bases[i] = rand_mac();
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_mask_modes();
        test_largest_key();
        test_overwrite();
        run_random_traffic(RANDOM_WORDS);
        test_table_full();

        @(negedge clk);
        start <= 1'b0;
        while (route_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * MRL_TABLE_ENTRIES + 4) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
